[hdl/lsgcd_pkg.sv]
package lsgcd_pkg;

  localparam int unsigned W = 64;
  localparam int unsigned LW = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMP,
    ST_LEAD,
    ST_STEP,
    ST_FIN,
    ST_DIV,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } state_t;

  function automatic logic [LW-1:0] lead_one(input logic [W-1:0] x);
    logic [LW-1:0] p;
    p = '0;
    for (int i = 0; i < W; i++) begin
      if (x[i]) p = LW'(i);
    end
    return p;
  endfunction

endpackage

[hdl/lsgcd_div.sv]
module lsgcd_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [lsgcd_pkg::W-1:0] num,
  input  logic [lsgcd_pkg::W-1:0] den,
  output logic                    done,
  output logic [lsgcd_pkg::W-1:0] quo
);
  import lsgcd_pkg::*;

  // restoring divider on magnitudes, one quotient bit per cycle
  logic [W-1:0] rem, q, d;
  logic [LW:0]  cnt;
  logic         busy;
  logic [W:0]   trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        q    <= num;
        d    <= den;
      end else if (busy) begin
        if (!trial[W]) begin
          rem <= trial[W-1:0];
          q   <= {q[W-2:0], 1'b1};
        end else begin
          rem <= {rem[W-2:0], q[W-1]};
          q   <= {q[W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == (LW+1)'(W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quo = q;
endmodule

[hdl/left_shift_extended_gcd.sv]
// channel | dir | tdata fields (low bit first)
// s_axis  | in  | operand_a[63:0], operand_b[127:64]
// m_axis  | out | gcd_value[62:0], pad bit 63, coef_a[127:64], coef_b[191:128]
// one item at a time: each reduction round runs compare, lead and step (a swap repeats
// the compare and an overshoot retries the step with k-1), then, unless the gcd is an
// operand magnitude or b is zero, the divider, six 32x32 multiply terms and a sign fix
// rst is synchronous and clears the sequencer; a held result stalls input
module left_shift_extended_gcd (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,   // operand_a, operand_b
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [191:0] m_axis_tdata    // gcd_value, pad, coef_a, coef_b
);
  import lsgcd_pkg::*;

  state_t state, state_next;
  logic [W-1:0] u1, u2, u3, v1, v2, v3, va, vb, mag_a, mag_b, q, sh, ra, rb;
  logic         neg_a, neg_b, dstart, ddone;
  logic [LW-1:0] k;
  logic [W-1:0] dq, aa, bb, s_res, t_res, p1, p2;
  logic [W-1:0] g_res;

  // shared 32x32 multiplier, low 64 bits of q*vb and q*va from three terms each
  logic [2:0]   mcnt;
  logic [31:0]  mop_q, mop_x;
  logic         msh;
  logic [63:0]  mprod, mterm;
  logic [W-1:0] qvb, qva;

  function automatic logic [W-1:0] sat(input logic [W-1:0] x);
    return (x == {1'b1, {(W-1){1'b0}}}) ? {1'b1, {(W-2){1'b0}}, 1'b1} : x;
  endfunction

  assign aa = sat(s_axis_tdata[63:0]);
  assign bb = sat(s_axis_tdata[127:64]);
  assign s_axis_tready = (state == ST_IDLE);

  // divide |u1| by |vb|, then sign fix (truncating division)
  logic [W-1:0] abs_u1, abs_vb;
  assign abs_u1 = u1[W-1] ? -u1 : u1;
  assign abs_vb = vb[W-1] ? -vb : vb;

  lsgcd_div u_div (.clk(clk), .rst(rst), .start(dstart), .num(abs_u1),
                   .den(abs_vb), .done(ddone), .quo(dq));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_CMP;
      ST_CMP:  state_next = (u3 < v3 || v3 == '0) ?
                            ((v3 == '0 && u3 >= v3) ? ST_FIN : ST_CMP) : ST_LEAD;
      ST_LEAD: state_next = ST_STEP;
      // step state retries with k-1 when the shifted value overshoots
      ST_STEP: state_next = (sh > u3) ? ST_STEP : ST_CMP;
      ST_FIN:  state_next = (u3 == mag_a || u3 == mag_b || vb == '0) ? ST_OUT : ST_DIV;
      ST_DIV:  if (ddone) state_next = ST_MUL;
      ST_MUL:  if (mcnt == 3'd5) state_next = ST_FIX;
      ST_FIX:  state_next = ST_OUT;
      ST_OUT:  if (m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    dstart = (state == ST_FIN) && (state_next == ST_DIV);
  end

  assign sh = v3 << k;
  assign ra = u3 - sh;
  assign rb = (sh << 1) - u3;

  // term order: lo*lo, lo*hi, hi*lo for vb, then the same for va
  always_comb begin
    case (mcnt)
      3'd0:    begin mop_q = q[31:0];  mop_x = vb[31:0];  msh = 1'b0; end
      3'd1:    begin mop_q = q[31:0];  mop_x = vb[63:32]; msh = 1'b1; end
      3'd2:    begin mop_q = q[63:32]; mop_x = vb[31:0];  msh = 1'b1; end
      3'd3:    begin mop_q = q[31:0];  mop_x = va[31:0];  msh = 1'b0; end
      3'd4:    begin mop_q = q[31:0];  mop_x = va[63:32]; msh = 1'b1; end
      default: begin mop_q = q[63:32]; mop_x = va[31:0];  msh = 1'b1; end
    endcase
  end

  assign mprod = {32'b0, mop_q} * {32'b0, mop_x};
  assign mterm = msh ? {mprod[31:0], 32'b0} : mprod;
  assign p1 = u1 - qvb;
  assign p2 = u2 + qva;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
    unique case (state)
      ST_IDLE: if (s_axis_tvalid) begin
        va <= aa; vb <= bb;
        neg_a <= aa[W-1]; neg_b <= bb[W-1];
        mag_a <= aa[W-1] ? -aa : aa; mag_b <= bb[W-1] ? -bb : bb;
        u3 <= aa[W-1] ? -aa : aa; v3 <= bb[W-1] ? -bb : bb;
        u1 <= W'(1); u2 <= '0; v1 <= '0; v2 <= W'(1);
      end
      ST_CMP: if (u3 < v3) begin
        u1 <= v1; v1 <= u1; u2 <= v2; v2 <= u2; u3 <= v3; v3 <= u3;
      end
      ST_LEAD: k <= lead_one(u3) - lead_one(v3);
      ST_STEP: begin
        if (sh > u3) k <= k - 1'b1;
        else begin
          u3 <= v3;
          if (ra < rb) begin
            v3 <= ra; v2 <= u2 - (v2 << k); u2 <= v2;
            v1 <= u1 - (v1 << k); u1 <= v1;
          end else begin
            v3 <= rb; v2 <= (v2 << (k + 1'b1)) - u2; u2 <= v2;
            v1 <= (v1 << (k + 1'b1)) - u1; u1 <= v1;
          end
        end
      end
      ST_FIN: begin
        g_res <= u3;
        if (u3 == mag_a) begin
          s_res <= neg_a ? '1 : W'(1); t_res <= '0;
        end else if (u3 == mag_b) begin
          s_res <= '0; t_res <= neg_b ? '1 : W'(1);
        end else if (vb == '0) begin
          s_res <= neg_a ? -u1 : u1; t_res <= neg_b ? -u2 : u2;
        end
      end
      ST_DIV: if (ddone) begin
        q    <= (u1[W-1] ^ vb[W-1]) ? -dq : dq;
        mcnt <= '0;
        qvb  <= '0;
        qva  <= '0;
      end
      ST_MUL: begin
        if (mcnt < 3'd3) qvb <= qvb + mterm;
        else             qva <= qva + mterm;
        mcnt <= mcnt + 1'b1;
      end
      ST_FIX: begin
        s_res <= neg_a ? -p1 : p1;
        t_res <= neg_b ? -p2 : p2;
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = (state == ST_OUT);
  assign m_axis_tdata  = {t_res, s_res, 1'b0, g_res[62:0]};
endmodule

[hdl/lsgcd_check.sv]
module lsgcd_check (
  input logic         clk,
  input logic         rst,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata
);
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result held");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !m_axis_tdata[63]) else $error("pad bit set");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
endmodule

bind left_shift_extended_gcd lsgcd_check u_check (.*);
